// ===== rtl/core/avm_pkg.sv =====
package avm_pkg;

  localparam int SAMPLE_W          = 10;
  localparam int SUM_W             = 14;
  localparam int CNT_W             = 5;
  localparam int SEG_W             = 7;
  localparam int BCD_W             = 8;
  localparam int SCALED_W          = 6;
  localparam int SCALE_TENTHS      = 33;
  localparam int MAX_SAMPLES       = 16;
  localparam int NUM_SAMPLES_RESET = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } avm_in_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic             low_digit_on;
    logic             high_digit_on;
  } avm_out_t;

  // Map the programmed count onto 1..16.
  function automatic logic [CNT_W-1:0] effective_samples(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] e;
    if (n == '0) begin
      e = CNT_W'(1);
    end else if (n > CNT_W'(MAX_SAMPLES)) begin
      e = CNT_W'(MAX_SAMPLES);
    end else begin
      e = n;
    end
    return e;
  endfunction

  // Split a reading of 0..63 into tens and units nibbles.
  function automatic logic [BCD_W-1:0] to_bcd(input logic [SCALED_W-1:0] v);
    logic [3:0]          tens;
    logic [SCALED_W-1:0] units;
    if (v >= SCALED_W'(60)) begin
      tens  = 4'd6;
      units = v - SCALED_W'(60);
    end else if (v >= SCALED_W'(50)) begin
      tens  = 4'd5;
      units = v - SCALED_W'(50);
    end else if (v >= SCALED_W'(40)) begin
      tens  = 4'd4;
      units = v - SCALED_W'(40);
    end else if (v >= SCALED_W'(30)) begin
      tens  = 4'd3;
      units = v - SCALED_W'(30);
    end else if (v >= SCALED_W'(20)) begin
      tens  = 4'd2;
      units = v - SCALED_W'(20);
    end else if (v >= SCALED_W'(10)) begin
      tens  = 4'd1;
      units = v - SCALED_W'(10);
    end else begin
      tens  = 4'd0;
      units = v;
    end
    return {tens, units[3:0]};
  endfunction

  // Hex digit to segment pattern, bit 0 = segment a.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      4'hF: s = 7'h71;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/avm_queue.sv =====
module avm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  avm_pkg::avm_in_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output avm_pkg::avm_in_t head_data
);
  import avm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  avm_in_t          entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign full       = (level_r == LVL_W'(QUEUE_DEPTH));
  assign head_valid = (level_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/avm_divider.sv =====
module avm_divider #(
  parameter int DIV_W = 16,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  import avm_pkg::*;

  localparam int STEP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/avm_back.sv =====
module avm_back #(
  parameter int SAMPLE_FULL_SCALE = 1023
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  avm_pkg::avm_in_t          head_data,
  output logic                      pop,
  input  logic [avm_pkg::CNT_W-1:0] num_samples,
  output logic                      out_valid,
  input  logic                      out_ready,
  output avm_pkg::avm_out_t         out_data
);
  import avm_pkg::*;

  localparam int FS_W  = $clog2(SAMPLE_FULL_SCALE + 1);
  localparam int NUM_W = $clog2(SAMPLE_FULL_SCALE * SCALE_TENTHS + SAMPLE_FULL_SCALE / 2 + 1);

  // Reciprocal of full scale: floor(x / FS) = (x * RECIP) >> RECIP_SHIFT
  // holds for every x below 2**NUM_W.
  localparam int     FS_LOG      = $clog2(SAMPLE_FULL_SCALE);
  localparam int     RECIP_SHIFT = NUM_W + FS_LOG;
  localparam int     RECIP_W     = NUM_W + 2;
  localparam int     PROD_W      = NUM_W + RECIP_W;
  localparam longint RECIP_FULL  = ((longint'(1) << RECIP_SHIFT) + SAMPLE_FULL_SCALE - 1)
                                   / SAMPLE_FULL_SCALE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_AVG   = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             show_high_r, show_high_nxt;
  logic             out_valid_r, out_valid_nxt;
  avm_out_t         out_data_r, out_data_nxt;
  logic [NUM_W-1:0] scaled_num_r, scaled_num_nxt;

  logic [SUM_W-1:0] sum_inc;
  logic [CNT_W-1:0] count_inc;
  logic             reading_done;
  logic             out_free;
  logic             take_sample, take_tick;

  logic                div_start, div_done;
  logic [SUM_W-1:0]    div_dividend, div_quo;
  logic [CNT_W-1:0]    div_divisor;
  logic [FS_W-1:0]     avg_clamp;
  logic [NUM_W-1:0]    num_scaled;
  logic [PROD_W-1:0]   scale_prod;
  logic [SCALED_W-1:0] tenths;
  logic [3:0]          digit;

  assign sum_inc      = sum_r + SUM_W'(head_data.sample);
  assign count_inc    = count_r + CNT_W'(1);
  assign reading_done = (count_inc >= effective_samples(num_samples));
  assign out_free     = !out_valid_r || out_ready;
  assign take_sample  = (state_r == ST_IDLE) && head_valid && (head_data.op == OP_SAMPLE);
  assign take_tick    = (state_r == ST_IDLE) && head_valid && (head_data.op == OP_TICK)
                        && out_free;
  assign pop          = take_sample || take_tick;

  // Saturate the average at full scale, times SCALE_TENTHS, plus FS/2 to round.
  assign avg_clamp  = (NUM_W'(div_quo) > NUM_W'(SAMPLE_FULL_SCALE)) ?
                      FS_W'(SAMPLE_FULL_SCALE) : div_quo[FS_W-1:0];
  assign num_scaled = NUM_W'(avg_clamp) * NUM_W'(SCALE_TENTHS)
                      + NUM_W'(SAMPLE_FULL_SCALE / 2);

  // Divide the registered numerator by full scale.
  assign scale_prod = PROD_W'(scaled_num_r) * PROD_W'(RECIP);
  assign tenths     = scale_prod[RECIP_SHIFT +: SCALED_W];

  assign div_start    = take_sample && reading_done;
  assign div_dividend = sum_inc;
  assign div_divisor  = count_inc;

  avm_divider #(
    .DIV_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign digit = show_high_r ? bcd_r[7:4] : bcd_r[3:0];

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    bcd_nxt        = bcd_r;
    show_high_nxt  = show_high_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    scaled_num_nxt = scaled_num_r;
    case (state_r)
      ST_IDLE: begin
        if (take_sample) begin
          if (reading_done) begin
            sum_nxt   = '0;
            count_nxt = '0;
            state_nxt = ST_AVG;
          end else begin
            sum_nxt   = sum_inc;
            count_nxt = count_inc;
          end
        end
        if (take_tick) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.segments      = seg_code(digit);
          out_data_nxt.low_digit_on  = !show_high_r;
          out_data_nxt.high_digit_on = show_high_r;
          show_high_nxt              = !show_high_r;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          scaled_num_nxt = num_scaled;
          state_nxt      = ST_SCALE;
        end
      end
      ST_SCALE: begin
        bcd_nxt   = to_bcd(tenths);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      bcd_r       <= '0;
      show_high_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      bcd_r       <= bcd_nxt;
      show_high_r <= show_high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    scaled_num_r <= scaled_num_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(MAX_SAMPLES))
    else $error("sample count passed the largest reading size");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (bcd_r[3:0] <= 4'd9) && (bcd_r[7:4] <= 4'd3))
    else $error("stored reading is not a valid 0.0 to 3.3 value");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !pop)
    else $error("item taken from the queue while a reading is in progress");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_AVG || state_r == ST_SCALE))
    else $error("divider finished with no division pending");

  a_tick_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    take_tick |=> (show_high_r != $past(show_high_r)))
    else $error("digit select did not alternate after a refresh tick");

endmodule

// ===== rtl/core/adc_average_voltmeter_display.sv =====
// Averaging voltmeter with a two-digit multiplexed seven-segment display.
//
// Input channel (in_valid/in_ready/in_data): each item is either a converter
// sample (op = 0) or a display refresh tick (op = 1). Samples are summed; once
// num_samples of them are in, the average is scaled to tenths of a volt
// (0.0 to 3.3 V) and stored as two BCD digits. Each tick yields one item on
// the output channel (out_valid/out_ready/out_data) with the segment pattern
// of the low digit, then the high digit, alternating. Samples yield nothing.
// Configuration channel (cfg_valid/cfg_data, always ready) sets num_samples;
// write it only while the block is idle.
// A tick's item goes through the queue entry and then the output register
// before it shows on out_valid. A sample that completes a reading holds the
// back end through a serial restoring division of the 14-bit sum by the
// sample count, one quotient bit per cycle; then the rounded numerator is
// registered and scaled by a reciprocal multiply in the ST_SCALE state.
// Reset clears sum, count and reading (display shows 0.0, low digit first)
// and sets num_samples to 8. A stalled receiver fills the output register,
// then the two-entry queue, and then in_ready drops.
module adc_average_voltmeter_display #(
  parameter int SAMPLE_FULL_SCALE = 1023
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  avm_pkg::avm_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output avm_pkg::avm_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [avm_pkg::CNT_W-1:0] cfg_data
);
  import avm_pkg::*;

  logic [CNT_W-1:0] num_samples_r, num_samples_nxt;
  logic             queue_full;
  logic             head_valid;
  avm_in_t          head_data;
  logic             pop;

  // Register writes are always taken.
  assign cfg_ready       = 1'b1;
  assign num_samples_nxt = (cfg_valid && cfg_ready) ? cfg_data : num_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_samples_r <= CNT_W'(NUM_SAMPLES_RESET);
    end else begin
      num_samples_r <= num_samples_nxt;
    end
  end

  // Front end: take any item while the queue has room; the back end sorts
  // samples from ticks at the queue head.
  assign in_ready = !queue_full;

  avm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_data  (in_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back end: accumulate, divide, convert and drive the display.
  avm_back #(
    .SAMPLE_FULL_SCALE (SAMPLE_FULL_SCALE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .num_samples (num_samples_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sim/avm_reading_checker.sv =====
module avm_reading_checker #(
  parameter int SAMPLE_FULL_SCALE = 1023
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  avm_pkg::avm_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  avm_pkg::avm_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [avm_pkg::CNT_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import avm_pkg::*;

  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic [BCD_W-1:0] shown_reading;
  logic             high_next;
  logic [CNT_W-1:0] samples_per_reading;
  avm_out_t         expected_digits[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      4'd9: p = 7'h6F;
      4'd10: p = 7'h77;
      4'd11: p = 7'h7C;
      4'd12: p = 7'h39;
      4'd13: p = 7'h5E;
      4'd14: p = 7'h79;
      default: p = 7'h71;
    endcase
    return p;
  endfunction

  // Zero reads as one, anything past the maximum as the maximum.
  function automatic logic [CNT_W-1:0] reading_length(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) r = CNT_W'(1);
    else if (n > CNT_W'(MAX_SAMPLES)) r = CNT_W'(MAX_SAMPLES);
    return r;
  endfunction

  function automatic logic [BCD_W-1:0] tenths_of_volt(input logic [SUM_W-1:0] total,
                                                      input logic [CNT_W-1:0] n);
    int unsigned fs;
    int unsigned avg;
    int unsigned scaled;
    fs = (SAMPLE_FULL_SCALE > 0) ? SAMPLE_FULL_SCALE : 1;
    avg = (n != '0) ? int'(total) / int'(n) : 0;
    if (avg > fs) avg = fs;
    scaled = (avg * SCALE_TENTHS + fs / 2) / fs;
    if (scaled > 99) scaled = 99;
    return {4'(scaled / 10), 4'(scaled % 10)};
  endfunction

  task automatic fold_sample(input logic [SAMPLE_W-1:0] s);
    acc_sum   = acc_sum + SUM_W'(s);
    acc_count = acc_count + 1'b1;
    if (acc_count >= reading_length(samples_per_reading)) begin
      shown_reading = tenths_of_volt(acc_sum, acc_count);
      acc_sum       = '0;
      acc_count     = '0;
    end
  endtask

  task automatic predict_digit();
    avm_out_t d;
    d.segments      = digit_pattern(high_next ? shown_reading[7:4] : shown_reading[3:0]);
    d.low_digit_on  = !high_next;
    d.high_digit_on = high_next;
    expected_digits.push_back(d);
    high_next = !high_next;
  endtask

  always @(posedge clk) begin
    avm_out_t want;
    if (!rst_n) begin
      acc_sum             = '0;
      acc_count           = '0;
      shown_reading       = '0;
      high_next           = 1'b0;
      samples_per_reading = CNT_W'(NUM_SAMPLES_RESET);
      expected_digits.delete();
    end else begin
      if (cfg_valid && cfg_ready) samples_per_reading = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.op == OP_TICK) predict_digit();
        else fold_sample(in_data.sample);
      end
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected digit: seg=%h lo=%b hi=%b", out_data.segments,
                     out_data.low_digit_on, out_data.high_digit_on);
          fail_count++;
        end else begin
          want = expected_digits.pop_front();
          if (out_data.segments !== want.segments ||
              out_data.low_digit_on !== want.low_digit_on ||
              out_data.high_digit_on !== want.high_digit_on) begin
            if (fail_count < 10)
              $display("digit mismatch: expected seg=%h lo=%b hi=%b, got seg=%h lo=%b hi=%b",
                       want.segments, want.low_digit_on, want.high_digit_on,
                       out_data.segments, out_data.low_digit_on, out_data.high_digit_on);
            fail_count++;
          end
        end
      end
    end
    pending = expected_digits.size();
  end

endmodule

// ===== sim/tb_adc_average_voltmeter_display.sv =====
module tb_adc_average_voltmeter_display;
  import avm_pkg::*;

  localparam int FULL_SCALE    = 1023;
  localparam int RESET_CYCLES  = 12;
  // Covers the division and scaling after a reading completes, with margin.
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 210;
  // Allow several times the slowest legal run.
  localparam int RUN_LIMIT     = 16_000_000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  avm_in_t          in_data   = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             in_ready;
  logic             out_valid;
  avm_out_t         out_data;
  logic             cfg_ready;
  int               fail_count;
  int               pending;

  int                burst_left = 1;
  logic [SAMPLE_W-1:0] sample_level = '0;
  logic [15:0]       ready_pattern = '0;
  int                pattern_age = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  adc_average_voltmeter_display #(
    .SAMPLE_FULL_SCALE(FULL_SCALE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  avm_reading_checker #(
    .SAMPLE_FULL_SCALE(FULL_SCALE)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver backpressure: rotate a 16-bit ready pattern and swap it for a
  // fresh one when pattern_age counts down to zero. Patterns range from always
  // ready, through random, down to a single ready bit in the pattern so the
  // output register and the queue behind it fill up and in_ready drops.
  always @(negedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom);
        2: ready_pattern <= 16'h0001;
        default: ready_pattern <= 16'h00FF;
      endcase
      pattern_age <= 63;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age - 1;
    end
    out_ready <= ready_pattern[0];
  end

  // Present one item and hold it until accepted. Items go out in bursts;
  // at the end of a burst drop valid for a gap, sometimes long enough to
  // land in the middle of a division.
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] value);
    avm_in_t item;
    int      gap;
    item.op     = op;
    item.sample = value;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Program num_samples only once the block is idle: drain every expected
  // digit, then give a completing sample time to finish its divisions.
  task automatic write_samples_per_reading(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random item: ticks carry junk in the ignored sample field. Samples
  // cluster around a level that moves now and then, so readings cover the
  // whole 0.0 to 3.3 range, with the rail values mixed in.
  task automatic send_random_item();
    int v;
    if ($urandom_range(0, 99) < 45) begin
      send_item(OP_TICK, SAMPLE_W'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0) sample_level = SAMPLE_W'($urandom_range(0, 1023));
      case ($urandom_range(0, 15))
        0: v = 0;
        1: v = 1023;
        2: v = $urandom_range(0, 1023);
        default: v = int'(sample_level) + $urandom_range(0, 64) - 32;
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_item(OP_SAMPLE, SAMPLE_W'(v));
    end
  endtask

  initial begin
    burst_left = $urandom_range(1, 24);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fresh display shows 0.0, low digit first.
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '1);
    // Default reading length of eight, all at full scale: 3.3 V.
    repeat (8) send_item(OP_SAMPLE, 10'h3FF);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);

    // Single-sample readings: zero, then the smallest value that rounds up.
    write_samples_per_reading(CNT_W'(1));
    send_item(OP_SAMPLE, '0);
    send_item(OP_TICK, '0);
    send_item(OP_SAMPLE, SAMPLE_W'(16));
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);

    // Lower the count mid-reading: the next sample closes the reading and
    // the sum is divided by the six samples actually taken.
    write_samples_per_reading(CNT_W'(MAX_SAMPLES));
    repeat (5) send_item(OP_SAMPLE, 10'h3FF);
    write_samples_per_reading(CNT_W'(3));
    send_item(OP_SAMPLE, '0);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);

    // Random phases, each under its own reading length: one, the maximum,
    // zero (reads as one), all ones (clamps to the maximum), then random.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_samples_per_reading(CNT_W'(1));
        1: write_samples_per_reading(CNT_W'(MAX_SAMPLES));
        2: write_samples_per_reading('0);
        3: write_samples_per_reading('1);
        4: write_samples_per_reading(CNT_W'($urandom_range(2, 15)));
        default: write_samples_per_reading(CNT_W'($urandom_range(0, 31)));
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Drain and let the back end go quiet before the verdict.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the run hangs, e.g. a digit that never shows up.
  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

endmodule
